FILE: src/detection_row_decoder_core_defines.svh
// Assertion macros for the detection row decoder core.
// Used by the top level only; expects signals named clock and reset in scope.
`ifndef DETECTION_ROW_DECODER_CORE_DEFINES_SVH
`define DETECTION_ROW_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DRD_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define DRD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/drd_pkg.sv
// Shared types and constants for the detection row decoder.
// No dependencies; imported by drd_axis and detection_row_decoder_core.
package drd_pkg;

   localparam int CSR_ADDR_WIDTH = 5;

   localparam logic [2:0] CSR_SCORE_THRESHOLD = 3'd0;
   localparam logic [2:0] CSR_GAIN_X          = 3'd1;
   localparam logic [2:0] CSR_GAIN_Y          = 3'd2;
   localparam logic [2:0] CSR_IMAGE_WIDTH     = 3'd3;
   localparam logic [2:0] CSR_IMAGE_HEIGHT    = 3'd4;
   localparam logic [2:0] CSR_SHIFT_X         = 3'd5;
   localparam logic [2:0] CSR_SHIFT_Y         = 3'd6;

   localparam logic [13:0] COORD_MAX = 14'h3FFF;

   typedef struct packed {
      logic signed [31:0] value;
      logic               row_end;
   } req_type;

   typedef struct packed {
      logic [13:0] left;
      logic [13:0] top;
      logic [13:0] right;
      logic [13:0] bottom;
      logic [31:0] confidence;
      logic [6:0]  class_id;
   } rsp_type;

   // Load strobes for the box pipeline stages.
   typedef struct packed {
      logic s2_load;
      logic s3_load;
   } drd_stage_en_type;

endpackage

FILE: src/drd_axis.sv
// One box axis: scale both edges by the gain, clamp to the image, offset by the shift.
// Depends on drd_pkg; stage strobes come from detection_row_decoder_core.
module drd_axis (
   input  logic                       clock,
   input  drd_pkg::drd_stage_en_type  stage_en,
   input  logic signed [31:0]         centre,
   input  logic signed [31:0]         extent,
   input  logic [23:0]                gain,
   input  logic [13:0]                image_size,
   input  logic [12:0]                shift,
   output logic [13:0]                start_px,
   output logic [13:0]                end_px
);
   import drd_pkg::*;

   logic signed [33:0] twice_c;
   logic signed [33:0] ext_s;
   logic signed [33:0] sum_lo;
   logic signed [33:0] sum_hi;
   logic signed [24:0] gain_s;
   logic signed [58:0] prod_lo_in, prod_hi_in;
   logic signed [58:0] prod_lo_ff, prod_hi_ff;
   logic [46:0]        limit;
   logic [46:0]        clamp_lo_in, clamp_hi_in;
   logic [46:0]        clamp_lo_ff, clamp_hi_ff;
   logic [46:0]        diff;
   logic [13:0]        corner;
   logic [13:0]        span;
   logic [15:0]        sum_start;
   logic [15:0]        sum_end;

   function automatic logic [46:0] clamp_edge(logic signed [58:0] e, logic [46:0] lim);
      logic [46:0] r;
      if (e < 0) begin
         r = '0;
      end else if (e > $signed({12'b0, lim})) begin
         r = lim;
      end else begin
         r = e[46:0];
      end
      return r;
   endfunction

   function automatic logic [13:0] sat_coord(logic [15:0] v);
      return (v > 16'(COORD_MAX)) ? COORD_MAX : v[13:0];
   endfunction

   // Edges in pixels with 33 fraction bits: (2*centre -/+ size) * gain.
   assign twice_c    = {centre[31], centre, 1'b0};
   assign ext_s      = {{2{extent[31]}}, extent};
   assign sum_lo     = twice_c - ext_s;
   assign sum_hi     = twice_c + ext_s;
   assign gain_s     = $signed({1'b0, gain});
   assign prod_lo_in = sum_lo * gain_s;
   assign prod_hi_in = sum_hi * gain_s;

   always_ff @(posedge clock) begin
      if (stage_en.s2_load) begin
         prod_lo_ff <= prod_lo_in;
         prod_hi_ff <= prod_hi_in;
      end
   end

   // An image size of zero clamps everything to zero.
   assign limit = (image_size == '0) ? '0 : {14'(image_size - 14'd1), 33'b0};
   assign clamp_lo_in = clamp_edge(prod_lo_ff, limit);
   assign clamp_hi_in = clamp_edge(prod_hi_ff, limit);

   always_ff @(posedge clock) begin
      if (stage_en.s3_load) begin
         clamp_lo_ff <= clamp_lo_in;
         clamp_hi_ff <= clamp_hi_in;
      end
   end

   assign corner = clamp_lo_ff[46:33];
   assign diff   = clamp_hi_ff - clamp_lo_ff;

   always_comb begin
      span = 14'd1;
      if (clamp_hi_ff > clamp_lo_ff && diff[46:33] != '0) begin
         span = diff[46:33];
      end
   end

   assign sum_start = 16'(corner) + 16'(shift);
   assign sum_end   = sum_start + 16'(span);
   assign start_px  = sat_coord(sum_start);
   assign end_px    = sat_coord(sum_end);

endmodule

FILE: src/detection_row_decoder_core.sv
// Detection row decoder: takes one prediction row element per cycle unless stalled
// (centre x, centre y, width, height, objectness, class scores; row_end on the last) and
// keeps a running argmax of the class scores. A request is taken every cycle that
// req_stall is low; req_stall rises only when a result is held by rsp_stall and the three
// row-end stages behind it are full. A row of five or more elements gives at most one
// result: the row is captured as its row_end request is taken, then passes one stage for
// the confidence and edge multipliers, one for threshold and clamping, and the result
// register, which takes the edge subtraction and offset.
// Depends on drd_pkg, drd_axis and detection_row_decoder_core_defines.svh.
`include "detection_row_decoder_core_defines.svh"

module detection_row_decoder_core #(
   parameter int MAX_ELEMENTS = 128
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  drd_pkg::req_type                    req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output drd_pkg::rsp_type                    rsp_payload,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [drd_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);
   import drd_pkg::*;

   // Configuration registers
   logic [16:0] thr_ff, thr_in;
   logic [23:0] gain_x_ff, gain_x_in, gain_y_ff, gain_y_in;
   logic [13:0] width_ff, width_in, height_ff, height_in;
   logic [12:0] shift_x_ff, shift_x_in, shift_y_ff, shift_y_in;
   logic        csr_write;
   logic [2:0]  csr_index;

   // Row accumulation
   logic [7:0]         count_ff, count_in;
   logic signed [31:0] cx_ff, cx_in, cy_ff, cy_in, w_ff, w_in, h_ff, h_in;
   logic signed [31:0] obj_ff, obj_in, best_ff, best_in;
   logic [6:0]         idx_ff, idx_in;
   logic signed [31:0] cx_nxt, cy_nxt, w_nxt, h_nxt, obj_nxt, best_nxt;
   logic [6:0]         idx_nxt;
   logic               accept, launch;
   logic [7:0]         pos;
   logic signed [31:0] v;

   // Stage 1: captured row
   logic               s1_valid_ff, s1_valid_in;
   logic signed [31:0] s1_cx_ff, s1_cy_ff, s1_w_ff, s1_h_ff, s1_obj_ff, s1_best_ff;
   logic [6:0]         s1_cls_ff;
   logic               s1_five_ff;

   // Stage 2: product
   logic               s2_valid_ff, s2_valid_in;
   logic signed [63:0] s2_prod_ff, s2_prod_in;
   logic [6:0]         s2_cls_ff;

   // Stage 3: thresholded confidence
   logic               s3_valid_ff, s3_valid_in;
   logic [31:0]        s3_conf_ff, s3_conf_in;
   logic [6:0]         s3_cls_ff;
   logic signed [47:0] conf;
   logic               pass;

   // Result register
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               out_free, s3_ready, s2_ready, s1_ready;
   drd_stage_en_type   stage_en;
   logic [13:0]        left_px, right_px, top_px, bottom_px;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[CSR_ADDR_WIDTH-1:2];

   always_comb begin
      thr_in     = thr_ff;
      gain_x_in  = gain_x_ff;
      gain_y_in  = gain_y_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      shift_x_in = shift_x_ff;
      shift_y_in = shift_y_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_SCORE_THRESHOLD: thr_in     = csr_pwdata[16:0];
            CSR_GAIN_X:          gain_x_in  = csr_pwdata[23:0];
            CSR_GAIN_Y:          gain_y_in  = csr_pwdata[23:0];
            CSR_IMAGE_WIDTH:     width_in   = csr_pwdata[13:0];
            CSR_IMAGE_HEIGHT:    height_in  = csr_pwdata[13:0];
            CSR_SHIFT_X:         shift_x_in = csr_pwdata[12:0];
            CSR_SHIFT_Y:         shift_y_in = csr_pwdata[12:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_SCORE_THRESHOLD: csr_prdata = 32'(thr_ff);
         CSR_GAIN_X:          csr_prdata = 32'(gain_x_ff);
         CSR_GAIN_Y:          csr_prdata = 32'(gain_y_ff);
         CSR_IMAGE_WIDTH:     csr_prdata = 32'(width_ff);
         CSR_IMAGE_HEIGHT:    csr_prdata = 32'(height_ff);
         CSR_SHIFT_X:         csr_prdata = 32'(shift_x_ff);
         CSR_SHIFT_Y:         csr_prdata = 32'(shift_y_ff);
         default:             csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff     <= 17'd16384;
         gain_x_ff  <= 24'd65536;
         gain_y_ff  <= 24'd65536;
         width_ff   <= 14'd640;
         height_ff  <= 14'd640;
         shift_x_ff <= '0;
         shift_y_ff <= '0;
      end else begin
         thr_ff     <= thr_in;
         gain_x_ff  <= gain_x_in;
         gain_y_ff  <= gain_y_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         shift_x_ff <= shift_x_in;
         shift_y_ff <= shift_y_in;
      end
   end

   // ---------------- pipeline flow ----------------
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s3_ready  = !s3_valid_ff || out_free;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_stall = !s1_ready;

   assign accept = req_valid && !req_stall;
   assign pos    = count_ff;
   assign v      = req_payload.value;

   // ---------------- row accumulation ----------------
   always_comb begin
      cx_nxt   = cx_ff;
      cy_nxt   = cy_ff;
      w_nxt    = w_ff;
      h_nxt    = h_ff;
      obj_nxt  = obj_ff;
      best_nxt = best_ff;
      idx_nxt  = idx_ff;
      priority if (pos == 8'd0) begin
         cx_nxt = v;
      end else if (pos == 8'd1) begin
         cy_nxt = v;
      end else if (pos == 8'd2) begin
         w_nxt = v;
      end else if (pos == 8'd3) begin
         h_nxt = v;
      end else if (pos == 8'd4) begin
         obj_nxt = v;
      end else if ({1'b0, pos} < 9'(MAX_ELEMENTS) && pos <= 8'd132 && v > best_ff) begin
         // class index pos-5 stays within 0..127
         best_nxt = v;
         idx_nxt  = 7'(pos - 8'd5);
      end
   end

   assign launch = accept && req_payload.row_end && pos >= 8'd4;

   always_comb begin
      count_in = count_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      w_in     = w_ff;
      h_in     = h_ff;
      obj_in   = obj_ff;
      best_in  = best_ff;
      idx_in   = idx_ff;
      if (accept) begin
         if (req_payload.row_end) begin
            count_in = '0;
            cx_in    = '0;
            cy_in    = '0;
            w_in     = '0;
            h_in     = '0;
            obj_in   = '0;
            best_in  = '0;
            idx_in   = '0;
         end else begin
            count_in = (count_ff == 8'hFF) ? count_ff : count_ff + 8'd1;
            cx_in    = cx_nxt;
            cy_in    = cy_nxt;
            w_in     = w_nxt;
            h_in     = h_nxt;
            obj_in   = obj_nxt;
            best_in  = best_nxt;
            idx_in   = idx_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         cx_ff    <= '0;
         cy_ff    <= '0;
         w_ff     <= '0;
         h_ff     <= '0;
         obj_ff   <= '0;
         best_ff  <= '0;
         idx_ff   <= '0;
      end else begin
         count_ff <= count_in;
         cx_ff    <= cx_in;
         cy_ff    <= cy_in;
         w_ff     <= w_in;
         h_ff     <= h_in;
         obj_ff   <= obj_in;
         best_ff  <= best_in;
         idx_ff   <= idx_in;
      end
   end

   // ---------------- stage 1: capture finished row ----------------
   assign s1_valid_in = s1_ready ? launch : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (s1_ready && launch) begin
         s1_cx_ff   <= cx_nxt;
         s1_cy_ff   <= cy_nxt;
         s1_w_ff    <= w_nxt;
         s1_h_ff    <= h_nxt;
         s1_obj_ff  <= obj_nxt;
         s1_best_ff <= best_nxt;
         s1_cls_ff  <= idx_nxt;
         s1_five_ff <= (pos == 8'd4);
      end
   end

   // ---------------- stage 2: confidence product ----------------
   // Five-element rows take objectness alone, scaled so the common shift applies.
   assign s2_prod_in = s1_five_ff ? $signed({{16{s1_obj_ff[31]}}, s1_obj_ff, 16'b0})
                                  : s1_obj_ff * s1_best_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;

   assign stage_en.s2_load = s2_ready && s1_valid_ff;
   assign stage_en.s3_load = s3_ready && s2_valid_ff;

   always_ff @(posedge clock) begin
      if (stage_en.s2_load) begin
         s2_prod_ff <= s2_prod_in;
         s2_cls_ff  <= s1_cls_ff;
      end
   end

   // ---------------- stage 3: threshold and saturate ----------------
   // Dropping the low 16 bits of a signed product floors it.
   assign conf = s2_prod_ff[63:16];
   assign pass = !(conf < $signed({31'b0, thr_ff}));

   always_comb begin
      if (conf[47]) begin
         s3_conf_in = '0;
      end else if (conf[46:32] != '0) begin
         s3_conf_in = '1;
      end else begin
         s3_conf_in = conf[31:0];
      end
   end

   assign s3_valid_in = s3_ready ? (s2_valid_ff && pass) : s3_valid_ff;

   always_ff @(posedge clock) begin
      if (stage_en.s3_load) begin
         s3_conf_ff <= s3_conf_in;
         s3_cls_ff  <= s2_cls_ff;
      end
   end

   // ---------------- box axes ----------------
   drd_axis u_axis_x (
      .clock      (clock),
      .stage_en   (stage_en),
      .centre     (s1_cx_ff),
      .extent     (s1_w_ff),
      .gain       (gain_x_ff),
      .image_size (width_ff),
      .shift      (shift_x_ff),
      .start_px   (left_px),
      .end_px     (right_px)
   );

   drd_axis u_axis_y (
      .clock      (clock),
      .stage_en   (stage_en),
      .centre     (s1_cy_ff),
      .extent     (s1_h_ff),
      .gain       (gain_y_ff),
      .image_size (height_ff),
      .shift      (shift_y_ff),
      .start_px   (top_px),
      .end_px     (bottom_px)
   );

   // ---------------- result register ----------------
   assign rsp_valid_in = out_free ? s3_valid_ff : rsp_valid_ff;

   always_comb begin
      rsp_in.left       = left_px;
      rsp_in.top        = top_px;
      rsp_in.right      = right_px;
      rsp_in.bottom     = bottom_px;
      rsp_in.confidence = s3_conf_ff;
      rsp_in.class_id   = s3_cls_ff;
   end

   always_ff @(posedge clock) begin
      if (out_free && s3_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // ---------------- assertions ----------------
   `DRD_ASSERT_NEXT(a_count_advance,
      accept && !req_payload.row_end && count_ff != 8'hFF,
      count_ff == $past(count_ff) + 8'd1,
      "element count did not advance on a mid-row request")
   `DRD_ASSERT_IMPLY(a_box_x_order, rsp_valid_ff,
      rsp_ff.right > rsp_ff.left || rsp_ff.right == COORD_MAX,
      "box right edge not beyond left edge")
   `DRD_ASSERT_IMPLY(a_box_y_order, rsp_valid_ff,
      rsp_ff.bottom > rsp_ff.top || rsp_ff.bottom == COORD_MAX,
      "box bottom edge not beyond top edge")
   `DRD_ASSERT_IMPLY(a_stall_cause, req_stall,
      s1_valid_ff && s2_valid_ff && s3_valid_ff && rsp_valid_ff,
      "request stalled while the row-end pipeline has room")

endmodule
